### design/rspnh_pkg.sv
// Package for the ray nearest-hit block: widths, register indexes, sequencer
// states, multiplier destinations and the request and response of the shared unit.
// No dependencies.
package rspnh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OPND_W    = 33;   // multiplier operand, signed
  localparam int PROD_W    = 66;   // full signed product
  localparam int ACC_W     = 52;   // dot-product accumulators, signed
  localparam int WIDE_W    = 100;  // exact a*|c| accumulator
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 50;
  localparam int RES_W     = 32;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X    = 3'd3;
  localparam logic [2:0] CFG_DIR_Y    = 3'd4;
  localparam logic [2:0] CFG_DIR_Z    = 3'd5;
  localparam logic [2:0] CFG_NEAR     = 3'd6;
  localparam logic [2:0] CFG_FAR      = 3'd7;

  localparam logic [3:0] K_PLANE_LAST = 4'd5;
  localparam logic [3:0] K_SPH_LAST   = 4'd9;
  localparam logic [3:0] K_AC_FIRST   = 4'd10;
  localparam logic [3:0] K_AC_LAST    = 4'd14;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WAIT, S_CHECK, S_DISC, S_SQRT, S_ROOT, S_DIV, S_FIN
  } rspnh_state_t;

  typedef enum logic [3:0] {
    D_NONE, D_ACC0, D_ACC1, D_ACC2, D_ACC2_SUB, D_H2, D_W0, D_W24, D_W25, D_W49
  } rspnh_dest_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } rspnh_iter_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } rspnh_iter_rsp_t;

endpackage

### design/rspnh_iter.sv
// Shared iterative unit: fixed-point quotient floor(n * 2^F / d) or integer
// square root, one result bit per cycle through one compare and subtract.
// Depends on rspnh_pkg.
module rspnh_iter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rspnh_pkg::rspnh_iter_req_t req,
  input  logic [rspnh_pkg::NUM_W-1:0] num,
  input  logic [rspnh_pkg::DEN_W-1:0] den,
  output rspnh_pkg::rspnh_iter_rsp_t rsp,
  output logic [rspnh_pkg::RES_W-1:0] res
);
  import rspnh_pkg::*;

  localparam int REM_W = 52;

  logic              busy_r, busy_nxt;
  logic              mode_r, mode_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  sh_r, sh_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              done_r, done_nxt;
  logic              ovf_r, ovf_nxt;
  logic [REM_W-1:0]  cand, trial;
  logic              ge;

  always_comb begin
    busy_nxt = busy_r;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    res_nxt  = res_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    if (mode_r) begin
      cand  = {rem_r[REM_W-3:0], sh_r[NUM_W-1:NUM_W-2]};
      trial = REM_W'({res_r, 2'b01});
    end else begin
      cand  = {rem_r[REM_W-2:0], sh_r[NUM_W-1]};
      trial = REM_W'(den_r);
    end
    ge = (cand >= trial);
    if (req.start) begin
      mode_nxt = req.sqrt_mode;
      den_nxt  = den;
      res_nxt  = '0;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
      if (req.sqrt_mode) begin
        rem_nxt  = '0;
        sh_nxt   = num;
        busy_nxt = 1'b1;
      end else begin
        rem_nxt = REM_W'(num[NUM_W-1:FRAC_BITS]);
        sh_nxt  = {num[FRAC_BITS-1:0], (NUM_W-FRAC_BITS)'(0)};
        // The quotient would not fit in the result word.
        if (num[NUM_W-1:FRAC_BITS] >= (NUM_W-FRAC_BITS)'(den)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          ovf_nxt  = 1'b1;
        end else begin
          busy_nxt = 1'b1;
        end
      end
    end else if (busy_r) begin
      rem_nxt = ge ? (cand - trial) : cand;
      sh_nxt  = mode_r ? (sh_r << 2) : (sh_r << 1);
      res_nxt = {res_r[RES_W-2:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
    mode_r <= mode_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    res_r  <= res_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign res      = res_r;

endmodule

### design/ray_sphere_plane_nearest_hit.sv
// Top level of the ray nearest-hit search against planes and spheres.
// Depends on rspnh_pkg and rspnh_iter.
//
// Usage: write the ray origin, direction and the near and far limits through
// the cfg_ port while the block is idle. Then stream objects on the in_ channel,
// one per transfer: tuser selects plane (0) or sphere (1), tdata holds point or
// centre, normal and diameter, and tlast marks the final object of the ray.
// Only the transfer with tlast set produces a result on the out_ channel:
// tuser is the hit flag, tdata the index and distance of the nearest hit.
// Each object is worked on alone: in_tready is high only while the sequencer
// is idle. The products go one per cycle through a single 33x33 multiplier,
// and the quotient and the square root share one restoring unit that yields
// one bit per cycle. A sphere takes longer than a plane, and longer still when
// its second root is divided too; early misses end sooner.
// The result sits in an output register; a stalled receiver holds it there,
// and the block keeps taking objects until another result is due, which
// then waits for the register to drain. Synchronous reset restores the
// register defaults and starts a fresh ray.
module ray_sphere_plane_nearest_hit #(
  parameter int MAX_OBJECTS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obj_x, obj_y, obj_z, norm_x, norm_y, norm_z, diameter (32 bits each)
  input  logic [223:0] in_tdata,
  // op
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_index [9:0], hit_distance [41:10], zero fill
  output logic [47:0]  out_tdata,
  // hit_found
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import rspnh_pkg::*;

  localparam int IDX_CAP_I = (MAX_OBJECTS - 1) < 1023 ? (MAX_OBJECTS - 1) : 1023;
  localparam logic [9:0] IDX_CAP = 10'(IDX_CAP_I);

  // Configuration registers.
  logic [31:0] org_x_r, org_y_r, org_z_r, dir_x_r, dir_y_r, dir_z_r, near_r, far_r;

  // Object held for the duration of its work.
  logic        op_r, op_nxt, last_r, last_nxt;
  logic [31:0] obj_x_r, obj_y_r, obj_z_r, nrm_x_r, nrm_y_r, nrm_z_r, diam_r;

  rspnh_state_t state_r, state_nxt;
  logic [3:0]   k_r, k_nxt;
  logic         rk_r, rk_nxt;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  rspnh_dest_t              ptag_r, ptag_nxt;
  logic signed [ACC_W-1:0]  acc0_r, acc0_nxt, acc1_r, acc1_nxt, acc2_r, acc2_nxt;
  logic [WIDE_W-1:0]        acw_r, acw_nxt;
  logic [63:0]              h2_r, h2_nxt;
  logic [47:0]              a_r, a_nxt;
  logic [49:0]              uc_r, uc_nxt;
  logic [31:0]              uh_r, uh_nxt;
  logic [31:0]              s_r, s_nxt;

  logic [31:0] best_r, best_nxt;
  logic [9:0]  idx_r, idx_nxt, count_r, count_nxt;
  logic        found_r, found_nxt;

  logic        out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  logic [9:0]  out_idx_r, out_idx_nxt;
  logic [31:0] out_dist_r, out_dist_nxt;

  rspnh_iter_req_t       ireq;
  rspnh_iter_rsp_t       irsp;
  logic [NUM_W-1:0]      inum;
  logic [DEN_W-1:0]      iden;
  logic [RES_W-1:0]      ires;

  // Operand selection for the shared multiplier.
  logic signed [OPND_W-1:0] mx, my, mz, dx, dy, dz, nx, ny, nz, rr;
  logic signed [OPND_W-1:0] opa, opb;
  rspnh_dest_t              dest;
  logic [3:0]               k_stop;

  // Checks and derived values.
  logic [ACC_W-1:0]   abs0, abs1, abs2;
  logic [64:0]        hsum;
  logic signed [53:0] hs, root;
  logic               in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  assign mx = $signed({obj_x_r[31], obj_x_r}) - $signed({org_x_r[31], org_x_r});
  assign my = $signed({obj_y_r[31], obj_y_r}) - $signed({org_y_r[31], org_y_r});
  assign mz = $signed({obj_z_r[31], obj_z_r}) - $signed({org_z_r[31], org_z_r});
  assign dx = $signed({dir_x_r[31], dir_x_r});
  assign dy = $signed({dir_y_r[31], dir_y_r});
  assign dz = $signed({dir_z_r[31], dir_z_r});
  assign nx = $signed({nrm_x_r[31], nrm_x_r});
  assign ny = $signed({nrm_y_r[31], nrm_y_r});
  assign nz = $signed({nrm_z_r[31], nrm_z_r});
  // Sphere radius is half the diameter.
  assign rr = $signed({2'b00, diam_r[31:1]});

  always_comb begin
    opa  = '0;
    opb  = '0;
    dest = D_NONE;
    // For a sphere, L = O - C is the negated plane offset, so products
    // with L use -m.
    case (k_r)
      4'd0: begin
        opa = op_r ? dx : mx;  opb = op_r ? dx : nx;  dest = D_ACC0;
      end
      4'd1: begin
        opa = op_r ? dy : my;  opb = op_r ? dy : ny;  dest = D_ACC0;
      end
      4'd2: begin
        opa = op_r ? dz : mz;  opb = op_r ? dz : nz;  dest = D_ACC0;
      end
      4'd3: begin
        opa = op_r ? -mx : dx; opb = op_r ? dx : nx;  dest = D_ACC1;
      end
      4'd4: begin
        opa = op_r ? -my : dy; opb = op_r ? dy : ny;  dest = D_ACC1;
      end
      4'd5: begin
        opa = op_r ? -mz : dz; opb = op_r ? dz : nz;  dest = D_ACC1;
      end
      4'd6: begin
        opa = mx; opb = mx; dest = D_ACC2;
      end
      4'd7: begin
        opa = my; opb = my; dest = D_ACC2;
      end
      4'd8: begin
        opa = mz; opb = mz; dest = D_ACC2;
      end
      4'd9: begin
        opa = rr; opb = rr; dest = D_ACC2_SUB;
      end
      4'd10: begin
        opa = $signed({1'b0, uh_r}); opb = $signed({1'b0, uh_r}); dest = D_H2;
      end
      4'd11: begin
        opa = $signed(OPND_W'(a_r[23:0]));  opb = $signed(OPND_W'(uc_r[24:0]));
        dest = D_W0;
      end
      4'd12: begin
        opa = $signed(OPND_W'(a_r[47:24])); opb = $signed(OPND_W'(uc_r[24:0]));
        dest = D_W24;
      end
      4'd13: begin
        opa = $signed(OPND_W'(a_r[23:0]));  opb = $signed(OPND_W'(uc_r[49:25]));
        dest = D_W25;
      end
      4'd14: begin
        opa = $signed(OPND_W'(a_r[47:24])); opb = $signed(OPND_W'(uc_r[49:25]));
        dest = D_W49;
      end
      default: begin
        opa = '0; opb = '0; dest = D_NONE;
      end
    endcase
  end

  assign k_stop = !op_r ? K_PLANE_LAST : ((k_r < K_AC_FIRST) ? K_SPH_LAST : K_AC_LAST);

  assign abs0 = acc0_r[ACC_W-1] ? $unsigned(-acc0_r) : $unsigned(acc0_r);
  assign abs1 = acc1_r[ACC_W-1] ? $unsigned(-acc1_r) : $unsigned(acc1_r);
  assign abs2 = acc2_r[ACC_W-1] ? $unsigned(-acc2_r) : $unsigned(acc2_r);
  assign hsum = {1'b0, h2_r} + {1'b0, acw_r[63:0]};
  assign hs   = 54'(acc1_r);
  assign root = rk_r ? (-hs + $signed({22'd0, s_r})) : (-hs - $signed({22'd0, s_r}));

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    rk_nxt        = rk_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    ptag_nxt      = D_NONE;
    acc0_nxt      = acc0_r;
    acc1_nxt      = acc1_r;
    acc2_nxt      = acc2_r;
    acw_nxt       = acw_r;
    h2_nxt        = h2_r;
    a_nxt         = a_r;
    uc_nxt        = uc_r;
    uh_nxt        = uh_r;
    s_nxt         = s_r;
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    ireq.start     = 1'b0;
    ireq.sqrt_mode = 1'b0;
    inum          = '0;
    iden          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt   = in_tuser;
          last_nxt = in_tlast;
          k_nxt    = '0;
          rk_nxt   = 1'b0;
          acc0_nxt = '0;
          acc1_nxt = '0;
          acc2_nxt = '0;
          acw_nxt  = '0;
          // A new ray starts from the far limit.
          if (count_r == '0) begin
            best_nxt  = far_r;
            idx_nxt   = '0;
            found_nxt = 1'b0;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt = opa * opb;
        ptag_nxt = dest;
        if (k_r == k_stop) begin
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_WAIT: begin
        // The last product lands in its accumulator during this cycle.
        state_nxt = (k_r == K_AC_LAST) ? S_DISC : S_CHECK;
      end
      S_CHECK: begin
        if (!op_r) begin
          // Plane: t = num / den with num and den of the same sign.
          if (acc1_r == '0 || acc0_r == '0 || (acc0_r[ACC_W-1] != acc1_r[ACC_W-1])) begin
            state_nxt = S_FIN;
          end else begin
            ireq.start = 1'b1;
            inum       = NUM_W'(abs0);
            iden       = DEN_W'(abs1);
            state_nxt  = S_DIV;
          end
        end else begin
          // Sphere: a must be positive and |h| must fit in 32 bits.
          if (acc0_r <= 0 || abs1[ACC_W-1:32] != '0) begin
            state_nxt = S_FIN;
          end else begin
            a_nxt     = acc0_r[47:0];
            uh_nxt    = abs1[31:0];
            uc_nxt    = abs2[49:0];
            k_nxt     = K_AC_FIRST;
            state_nxt = S_MUL;
          end
        end
      end
      S_DISC: begin
        // disc = h*h - a*c, rejected when it leaves 64 bits or is not positive.
        if (acw_r[WIDE_W-1:64] != '0) begin
          state_nxt = S_FIN;
        end else if (!acc2_r[ACC_W-1]) begin
          if (acw_r[63:0] >= h2_r) begin
            state_nxt = S_FIN;
          end else begin
            ireq.start     = 1'b1;
            ireq.sqrt_mode = 1'b1;
            inum           = h2_r - acw_r[63:0];
            state_nxt      = S_SQRT;
          end
        end else begin
          if (hsum[64]) begin
            state_nxt = S_FIN;
          end else begin
            ireq.start     = 1'b1;
            ireq.sqrt_mode = 1'b1;
            inum           = hsum[63:0];
            state_nxt      = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (irsp.done) begin
          s_nxt     = ires;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root <= 0) begin
          if (!rk_r) begin
            rk_nxt = 1'b1;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          ireq.start = 1'b1;
          inum       = NUM_W'($unsigned(root));
          iden       = DEN_W'(a_r);
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (irsp.done) begin
          state_nxt = S_FIN;
          if (!irsp.ovf) begin
            if (!op_r) begin
              if (ires > near_r && ires < best_r) begin
                best_nxt  = ires;
                idx_nxt   = count_r;
                found_nxt = 1'b1;
              end
            end else if (ires <= near_r) begin
              // Near root too close: try the far root once.
              if (!rk_r) begin
                rk_nxt    = 1'b1;
                state_nxt = S_ROOT;
              end
            end else if (ires < best_r) begin
              best_nxt  = ires;
              idx_nxt   = count_r;
              found_nxt = 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        if (!last_r) begin
          if (count_r < IDX_CAP) begin
            count_nxt = count_r + 10'd1;
          end
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_idx_nxt   = found_r ? idx_r : '0;
          out_dist_nxt  = found_r ? best_r : '0;
          count_nxt     = '0;
          found_nxt     = 1'b0;
          idx_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Products from the previous cycle are folded in, rounded toward minus
    // infinity for the dot products and exact for h*h and a*|c|.
    case (ptag_r)
      D_ACC0:     acc0_nxt = acc0_r + ACC_W'(prod_r >>> FRAC_BITS);
      D_ACC1:     acc1_nxt = acc1_r + ACC_W'(prod_r >>> FRAC_BITS);
      D_ACC2:     acc2_nxt = acc2_r + ACC_W'(prod_r >>> FRAC_BITS);
      D_ACC2_SUB: acc2_nxt = acc2_r - ACC_W'(prod_r >>> FRAC_BITS);
      D_H2:       h2_nxt   = prod_r[63:0];
      D_W0:       acw_nxt  = acw_r + WIDE_W'($unsigned(prod_r));
      D_W24:      acw_nxt  = acw_r + (WIDE_W'($unsigned(prod_r)) << 24);
      D_W25:      acw_nxt  = acw_r + (WIDE_W'($unsigned(prod_r)) << 25);
      D_W49:      acw_nxt  = acw_r + (WIDE_W'($unsigned(prod_r)) << 49);
      default:    acw_nxt  = acw_nxt;
    endcase
  end

  rspnh_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .num   (inum),
    .den   (iden),
    .rsp   (irsp),
    .res   (ires)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= 32'd65536;
      near_r  <= 32'd66;
      far_r   <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: org_x_r <= cfg_wdata;
        CFG_ORIGIN_Y: org_y_r <= cfg_wdata;
        CFG_ORIGIN_Z: org_z_r <= cfg_wdata;
        CFG_DIR_X:    dir_x_r <= cfg_wdata;
        CFG_DIR_Y:    dir_y_r <= cfg_wdata;
        CFG_DIR_Z:    dir_z_r <= cfg_wdata;
        CFG_NEAR:     near_r  <= cfg_wdata;
        CFG_FAR:      far_r   <= cfg_wdata;
        default:      near_r  <= near_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptag_r      <= D_NONE;
      k_r         <= '0;
      rk_r        <= 1'b0;
      count_r     <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptag_r      <= ptag_nxt;
      k_r         <= k_nxt;
      rk_r        <= rk_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    prod_r      <= prod_nxt;
    acc0_r      <= acc0_nxt;
    acc1_r      <= acc1_nxt;
    acc2_r      <= acc2_nxt;
    acw_r       <= acw_nxt;
    h2_r        <= h2_nxt;
    a_r         <= a_nxt;
    uc_r        <= uc_nxt;
    uh_r        <= uh_nxt;
    s_r         <= s_nxt;
    best_r      <= best_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
    if (in_xfer) begin
      obj_x_r <= in_tdata[31:0];
      obj_y_r <= in_tdata[63:32];
      obj_z_r <= in_tdata[95:64];
      nrm_x_r <= in_tdata[127:96];
      nrm_y_r <= in_tdata[159:128];
      nrm_z_r <= in_tdata[191:160];
      diam_r  <= in_tdata[223:192];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {6'd0, out_dist_r, out_idx_r};

  // The shared unit only answers while the sequencer waits for it.
  a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
    irsp.done |-> (state_r == S_SQRT || state_r == S_DIV))
    else $error("shared unit finished outside a wait state");

  // Products are only in flight right after an issue cycle.
  a_prod_src: assert property (@(posedge clk) disable iff (!rst_n)
    (ptag_r != D_NONE) |-> ($past(state_r) == S_MUL))
    else $error("product without an issue cycle");

  // An accepted object starts the multiply sequence at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MUL && k_r == '0))
    else $error("object transfer did not start the sequence");

  // The object counter never passes the index cap.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IDX_CAP)
    else $error("object index beyond cap");

endmodule

### tb/sv/ray_sphere_plane_nearest_hit_tb.sv
// Self-checking testbench for ray_sphere_plane_nearest_hit: directed objects, a saturating
// long ray, random rays under several idling phases and an output back-pressure phase.
// Depends on rspnh_pkg and the RTL of the block.
`timescale 1ns / 1ps

module ray_sphere_plane_nearest_hit_tb;
  import rspnh_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One expected ray answer as the result channel carries it.
  typedef struct packed {
    logic        found;
    logic [9:0]  idx;
    logic [31:0] hit_dist;
  } hit_t;

  // One directed object; typed rows carry an answer worked out by hand.
  typedef struct {
    logic        op;
    logic [31:0] px, py, pz, nx, ny, nz, diam;
    logic        last;
    logic        typed;
    hit_t        res;
  } obj_row_t;

  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam logic [31:0] NEG5  = 32'hFFFB_0000;
  localparam logic        PLANE = 1'b0;
  localparam logic        SPHERE = 1'b1;
  localparam int          IDX_CAP = 1023;
  localparam int          SETTLE = 200;  // settle time, longer than the slowest object

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  ray_sphere_plane_nearest_hit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the ray registers, updated at each register write.
  logic [31:0] ray_org[3];
  logic [31:0] ray_dir[3];
  logic [31:0] near_lim, far_lim;

  // Search state of the ray in flight.
  logic [31:0] best_dist;
  logic [9:0]  best_idx;
  logic [9:0]  obj_count;
  logic        found_any;

  hit_t pending_hits[$];
  int   errs = 0;
  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers. Products are exact and then floored by 16 fraction
  // bits; the arithmetic shift of a signed value floors toward minus infinity.
  // ---------------------------------------------------------------------------
  function automatic wide_t sx(input logic [31:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic wide_t fx_mul(input wide_t a, input wide_t b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic wide_t mag(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Quotient n * 2^16 / d, refused when it does not fit in 32 bits.
  function automatic bit fx_div(input wide_t n, input wide_t d, output logic [31:0] t);
    wide_t q;
    q = (n <<< FRAC_BITS) / d;
    t = q[31:0];
    return q < (wide_t'(1) <<< 32);
  endfunction

  function automatic wide_t floor_sqrt(input wide_t v);
    wide_t root, cand;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (wide_t'(1) <<< i);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Ray against plane: t = ((P - O) . N) / (D . N), both signs must agree.
  function automatic bit plane_t(input logic [223:0] d, output logic [31:0] t);
    wide_t num, den;
    t = '0;
    num = fx_mul(sx(d[31:0]) - sx(ray_org[0]), sx(d[127:96]))
        + fx_mul(sx(d[63:32]) - sx(ray_org[1]), sx(d[159:128]))
        + fx_mul(sx(d[95:64]) - sx(ray_org[2]), sx(d[191:160]));
    den = fx_mul(sx(ray_dir[0]), sx(d[127:96]))
        + fx_mul(sx(ray_dir[1]), sx(d[159:128]))
        + fx_mul(sx(ray_dir[2]), sx(d[191:160]));
    if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return 1'b0;
    if (!fx_div(mag(num), mag(den), t)) return 1'b0;
    return (t > near_lim) && (t < best_dist);
  endfunction

  // Ray against sphere: quadratic with half-diameter radius; the nearer root
  // above the near limit is taken, and any datapath overflow is a miss.
  function automatic bit sphere_t(input logic [223:0] d, output logic [31:0] t);
    wide_t l[3];
    wide_t a, h, ll, r, c, h2, ac, disc, s;
    wide_t roots[2];
    wide_t lim64;
    t = '0;
    lim64 = wide_t'(1) <<< 64;
    for (int i = 0; i < 3; i++) l[i] = sx(ray_org[i]) - sx(d[32*i +: 32]);
    a = 0; h = 0; ll = 0;
    for (int i = 0; i < 3; i++) begin
      a  = a + fx_mul(sx(ray_dir[i]), sx(ray_dir[i]));
      h  = h + fx_mul(l[i], sx(ray_dir[i]));
      ll = ll + ((mag(l[i]) * mag(l[i])) >>> FRAC_BITS);
    end
    r = wide_t'(d[223:192] >> 1);
    c = ll - ((r * r) >>> FRAC_BITS);
    if (a <= 0) return 1'b0;
    if (mag(h) >= (wide_t'(1) <<< 32)) return 1'b0;
    h2 = h * h;
    ac = a * mag(c);
    if (ac >= lim64) return 1'b0;
    if (c >= 0) begin
      if (ac >= h2) return 1'b0;
      disc = h2 - ac;
    end else begin
      if (h2 + ac >= lim64) return 1'b0;
      disc = h2 + ac;
    end
    s = floor_sqrt(disc);
    roots[0] = -h - s;
    roots[1] = -h + s;
    for (int k = 0; k < 2; k++) begin
      if (roots[k] > 0) begin
        if (!fx_div(roots[k], a, t)) return 1'b0;
        if (t > near_lim) return t < best_dist;
      end
    end
    return 1'b0;
  endfunction

  // Advances the search by one accepted object; the final object of a ray
  // queues the answer and restarts the search.
  task automatic track_object(input logic op, input logic [223:0] d, input logic last,
                              input bit typed, input hit_t typed_res);
    logic [31:0] t;
    bit hit;
    hit_t res;
    if (obj_count == 0) begin
      best_dist = far_lim;
      best_idx  = '0;
      found_any = 1'b0;
    end
    hit = (op == SPHERE) ? sphere_t(d, t) : plane_t(d, t);
    if (hit) begin
      best_dist = t;
      best_idx  = obj_count;
      found_any = 1'b1;
    end
    if (obj_count < IDX_CAP) obj_count++;
    if (last) begin
      res.found    = found_any;
      res.idx      = found_any ? best_idx : '0;
      res.hit_dist = found_any ? best_dist : '0;
      pending_hits.push_back(typed ? typed_res : res);
      obj_count = '0;
      found_any = 1'b0;
      best_idx  = '0;
      best_dist = far_lim;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven at the falling edge; handshakes are read in
  // the active region right after the rising edge, so they see pre-edge values.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ORIGIN_X: ray_org[0] = val;
      CFG_ORIGIN_Y: ray_org[1] = val;
      CFG_ORIGIN_Z: ray_org[2] = val;
      CFG_DIR_X:    ray_dir[0] = val;
      CFG_DIR_Y:    ray_dir[1] = val;
      CFG_DIR_Z:    ray_dir[2] = val;
      CFG_NEAR:     near_lim = val;
      default:      far_lim = val;
    endcase
  endtask

  task automatic send_object(input logic op, input logic [223:0] d, input logic last,
                             input bit typed, input hit_t typed_res);
    in_tuser  = op;
    in_tdata  = d;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    track_object(op, d, last, typed, typed_res);
    @(negedge clk);
    // A random gap drops valid and keeps it low while further draws stay under the idle percentage.
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Waits for every queued answer, then lets a miss-only object finish too.
  task automatic drain;
    in_tvalid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random content.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] near_val(input int span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  task automatic program_ray;
    logic [31:0] v;
    int pick;
    for (int i = 0; i < 3; i++)
      write_reg(CFG_ORIGIN_X + 3'(i), ($urandom_range(9) == 0) ? $urandom : near_val(8 * ONE));
    pick = $urandom_range(19);
    for (int i = 0; i < 3; i++) begin
      if (pick == 0) v = '0;
      else if (pick < 3) v = $urandom;
      else v = near_val(2 * ONE);
      write_reg(CFG_DIR_X + 3'(i), v);
    end
    pick = $urandom_range(19);
    if (pick < 14) v = $urandom_range(1024);
    else if (pick < 17) v = '0;
    else if (pick < 19) v = $urandom;
    else v = '1;
    write_reg(CFG_NEAR, v);
    pick = $urandom_range(19);
    if (pick < 14) v = '1;
    else if (pick < 18) v = $urandom_range(ONE, 64 * ONE);
    else if (pick == 18) v = '0;
    else v = $urandom;
    write_reg(CFG_FAR, v);
  endtask

  // Most objects sit along the ray so that hits and misses both happen;
  // the rest are raw noise over every bit.
  task automatic random_ray(input int len);
    logic [223:0] d;
    logic op;
    int k;
    for (int n = 0; n < len; n++) begin
      op = 1'($urandom);
      if ($urandom_range(4) == 0) begin
        for (int w = 0; w < 7; w++) d[32*w +: 32] = $urandom;
      end else begin
        k = $urandom_range(1, 12);
        for (int i = 0; i < 3; i++) begin
          d[32*i +: 32]      = ray_org[i] + ray_dir[i] * k + near_val(ONE);
          d[96 + 32*i +: 32] = near_val(2 * ONE);
        end
        d[223:192] = $urandom_range(8 * ONE);
      end
      send_object(op, d, n == len - 1, 0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus a long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Checker: each result transfer is matched with the oldest queued answer.
  always @(posedge clk) begin
    hit_t exp_hit;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        $error("result transfer with no answer expected");
        errs++;
      end else begin
        exp_hit = pending_hits.pop_front();
        if (out_tuser !== exp_hit.found) begin
          $error("hit_found: expected %0d, got %0d", exp_hit.found, out_tuser);
          errs++;
        end
        if (out_tdata[9:0] !== exp_hit.idx) begin
          $error("hit_index: expected %0d, got %0d", exp_hit.idx, out_tdata[9:0]);
          errs++;
        end
        if (out_tdata[41:10] !== exp_hit.hit_dist) begin
          $error("hit_distance: expected %h, got %h", exp_hit.hit_dist, out_tdata[41:10]);
          errs++;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  obj_row_t rows[13];
  logic [223:0] d;
  int budget;

  initial begin
    // Reset values of the ray registers: origin zero, direction +z, near 66,
    // far all ones. Coordinates are Q16.16.
    ray_org = '{32'h0, 32'h0, 32'h0};
    ray_dir = '{32'h0, 32'h0, ONE};
    near_lim = 32'd66;
    far_lim = '1;
    best_dist = '1;
    best_idx = '0;
    obj_count = '0;
    found_any = 1'b0;

    rows = '{
      // Plane at z = 5 facing the ray: hit at t = 5.
      '{PLANE, 0, 0, 5*ONE, 0, 0, ONE, 0, 1, 1, '{1'b1, 10'd0, 32'h0005_0000}},
      // Plane parallel to the ray: no hit.
      '{PLANE, 0, 0, 5*ONE, ONE, 0, 0, 0, 1, 1, '{1'b0, 10'd0, 32'h0}},
      // Plane behind the origin: no hit.
      '{PLANE, 0, 0, NEG5, 0, 0, ONE, 0, 1, 1, '{1'b0, 10'd0, 32'h0}},
      // Plane closer than the near limit: no hit.
      '{PLANE, 0, 0, 32'h40, 0, 0, ONE, 0, 1, 1, '{1'b0, 10'd0, 32'h0}},
      // Sphere ahead, radius 2 at z = 10: nearer root t = 8.
      '{SPHERE, 0, 0, 10*ONE, 0, 0, 0, 4*ONE, 1, 1, '{1'b1, 10'd0, 32'h0008_0000}},
      // Origin inside the sphere: only the far root counts, t = 2.
      '{SPHERE, 0, 0, 0, 0, 0, 0, 4*ONE, 1, 1, '{1'b1, 10'd0, 32'h0002_0000}},
      // Tangent sphere: zero discriminant, no hit.
      '{SPHERE, 2*ONE, 0, 10*ONE, 0, 0, 0, 4*ONE, 1, 1, '{1'b0, 10'd0, 32'h0}},
      // Three objects in one ray; the last one, a reversed plane at z = 3, wins.
      '{PLANE, 0, 0, 20*ONE, 0, 0, ONE, 0, 0, 0, '{1'b0, 10'd0, 32'h0}},
      '{SPHERE, 0, 0, 10*ONE, 0, 0, 0, 4*ONE, 0, 0, '{1'b0, 10'd0, 32'h0}},
      '{PLANE, 0, 0, 3*ONE, 0, 0, 32'hFFFF_0000, 0, 1, 1, '{1'b1, 10'd2, 32'h0003_0000}},
      // Field extremes, checked against the predictor.
      '{PLANE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, '{1'b0, 10'd0, 32'h0}},
      '{SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1, 0, '{1'b0, 10'd0, 32'h0}},
      // Point sphere of diameter zero.
      '{SPHERE, 0, 0, 10*ONE, 0, 0, 0, 0, 1, 0, '{1'b0, 10'd0, 32'h0}}
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      d = {rows[i].diam, rows[i].nz, rows[i].ny, rows[i].nx,
           rows[i].pz, rows[i].py, rows[i].px};
      send_object(rows[i].op, d, rows[i].last, rows[i].typed, rows[i].res);
    end

    // A ray longer than the index range: parallel planes miss, and the final
    // plane hits with the index held at its top value.
    for (int n = 0; n < 1026; n++) begin
      if (n == 1025) d = {32'h0, ONE, 64'h0, 32'h0002_0000, 64'h0};
      else d = {32'h0, 64'h0, ONE, 32'h0005_0000, 64'h0};
      send_object(PLANE, d, n == 1025, 0, '0);
    end

    // Random rays under each idling phase; the registers change between rays.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 18 : 0;
      recv_stall_pct  = (ph == 2) ? 78 : (ph == 3) ? 18 : 0;
      budget = 15;
      while (budget > 0) begin
        drain();
        program_ray();
        d[31:0] = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        random_ray(d[31:0]);
        budget -= d[31:0];
      end
    end

    // Back-pressure: the receiver holds off while short rays keep coming, so
    // the output register fills and the input side stalls.
    drain();
    sender_idle_pct = 0;
    recv_stall_pct = 30;
    hold_cycles = 3000;
    for (int n = 0; n < 10; n++) random_ray($urandom_range(1, 3));

    drain();
    if (errs == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
